@@ rtl/tfd_pkg.sv @@
// Shared types and constants of the tank fill, dose and flood sequencer.
// Used by tfd_core, tfd_skid and the top level; depends on nothing.
package tfd_pkg;

	localparam int DOSE_TICKS       = 20;
	localparam int SETTLE_TICKS     = 10;
	localparam int HOLD_TICKS       = 50;
	localparam int TICKS_PER_MINUTE = 600;

	localparam int LEVEL_BAND = 10;
	localparam int PH_BAND    = 20;

	localparam int CNT_W = 18;

	localparam logic [11:0] MAX_LEVEL_RST   = 12'd1000;
	localparam logic [10:0] PH_SETPOINT_RST = 11'd600;
	localparam logic [7:0]  FLOOD_MIN_RST   = 8'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_LEVEL   = 2'd0;
	localparam logic [1:0] REG_PH_SETPOINT = 2'd1;
	localparam logic [1:0] REG_FLOOD_MIN   = 2'd2;

	// Opcodes.
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_FILL     = 2'd1;
	localparam logic [1:0] OP_REGULATE = 2'd2;
	localparam logic [1:0] OP_FLOOD    = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_FILL_RUN  = 3'd1;
	localparam logic [2:0] ST_FILL_DONE = 3'd2;
	localparam logic [2:0] ST_REG_RUN   = 3'd3;
	localparam logic [2:0] ST_REG_DONE  = 3'd4;
	localparam logic [2:0] ST_FLD_RUN   = 3'd5;
	localparam logic [2:0] ST_FLD_DONE  = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_FILL,
		PH_DOSE,
		PH_SETTLE,
		PH_HOLD,
		PH_REST,
		PH_FLOOD
	} phase_t;

	typedef struct packed {
		logic [11:0]      max_level;
		logic [10:0]      ph_setpoint;
		logic [CNT_W-1:0] flood_total;
	} cfg_t;

	typedef struct packed {
		logic       inlet_valve;
		logic       outlet_valve;
		logic       mixing_valve;
		logic       flood_pump;
		logic       acid_pump;
		logic [2:0] status;
	} res_t;

endpackage

@@ rtl/tank_fill_dose_flood_sequencer.sv @@
// Top level of the tank fill, dose and flood sequencer: configuration
// registers, the sequencer core and the result buffer.
// Depends on tfd_pkg, tfd_core and tfd_skid.
//
// Usage: every input request is one 100 ms tick. It carries an opcode (tick
// only, start fill, start regulate, start flood), the water level in tenths
// and the averaged pH in hundredths. While idle, a start opcode begins a job
// and that same tick is its first tick; opcodes given while a job runs are
// ignored. Each accepted request yields exactly one result request with the
// five drive bits for that tick and the status after it.
// Both channels use valid and stall; a request moves at a rising edge where
// valid is high and stall is low. An accepted result is registered, in the
// output register or the skid stage. Throughput is one request per cycle
// while in_stall is low: the whole tick update is a single pass of compare
// and count logic in the core, between the state and output registers.
// When the receiver stalls, one result waits in the output register and a
// second one goes into the skid stage; only then is in_stall raised, and it
// drops as soon as the receiver takes a result.
// Reset (arst_n low) puts the sequencer idle with status idle, empties the
// result buffer and loads the default configuration: level 1000, pH 600 and
// five flood minutes. Configuration is written through cfg_we, cfg_index and
// cfg_wdata, by the user only while no request is in flight; not enforced.
module tank_fill_dose_flood_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [11:0] water_level,
	input  logic [10:0] avg_ph,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        inlet_valve,
	output logic        outlet_valve,
	output logic        mixing_valve,
	output logic        flood_pump,
	output logic        acid_pump,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata
);

	tfd_pkg::cfg_t cfg_q;
	tfd_pkg::res_t core_res, out_res;
	logic          accept;

	// The flood length in ticks is formed once, when the minutes are written,
	// so the core only has to compare its counter against it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level   <= tfd_pkg::MAX_LEVEL_RST;
			cfg_q.ph_setpoint <= tfd_pkg::PH_SETPOINT_RST;
			cfg_q.flood_total <= tfd_pkg::CNT_W'(tfd_pkg::FLOOD_MIN_RST)
				* tfd_pkg::CNT_W'(tfd_pkg::TICKS_PER_MINUTE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfd_pkg::REG_MAX_LEVEL:   cfg_q.max_level <= cfg_wdata;
				tfd_pkg::REG_PH_SETPOINT: cfg_q.ph_setpoint <= cfg_wdata[10:0];
				tfd_pkg::REG_FLOOD_MIN: begin
					cfg_q.flood_total <= tfd_pkg::CNT_W'(cfg_wdata[7:0])
						* tfd_pkg::CNT_W'(tfd_pkg::TICKS_PER_MINUTE);
				end
				default: begin
				end
			endcase
		end
	end

	// A tick is taken whenever the result buffer has room for its result.
	assign accept = in_valid && !in_stall;

	tfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.water_level (water_level),
		.avg_ph      (avg_ph),
		.cfg         (cfg_q),
		.res         (core_res)
	);

	tfd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (core_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign inlet_valve  = out_res.inlet_valve;
	assign outlet_valve = out_res.outlet_valve;
	assign mixing_valve = out_res.mixing_valve;
	assign flood_pump   = out_res.flood_pump;
	assign acid_pump    = out_res.acid_pump;
	assign status       = out_res.status;

endmodule

@@ rtl/tfd_core.sv @@
// Sequencer state and the per-tick next-state and drive logic.
// Depends on tfd_pkg.
module tfd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            opcode,
	input  logic [11:0]           water_level,
	input  logic [10:0]           avg_ph,
	input  tfd_pkg::cfg_t         cfg,
	output tfd_pkg::res_t         res
);

	tfd_pkg::phase_t              phase_q, phase_d, ph_eff;
	logic [tfd_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_eff, cnt_inc;
	logic [2:0]                   status_q, status_d, status_eff;
	logic signed [12:0]           lvl_diff, lvl_abs;
	logic signed [11:0]           ph_diff, ph_abs;
	logic                         lvl_off, ph_off, start;

	always_comb begin
		lvl_diff = $signed({1'b0, water_level}) - $signed({1'b0, cfg.max_level});
		lvl_abs  = lvl_diff[12] ? -lvl_diff : lvl_diff;
		lvl_off  = lvl_abs > $signed(13'(tfd_pkg::LEVEL_BAND));
		ph_diff  = $signed({1'b0, avg_ph}) - $signed({1'b0, cfg.ph_setpoint});
		ph_abs   = ph_diff[11] ? -ph_diff : ph_diff;
		ph_off   = ph_abs > $signed(12'(tfd_pkg::PH_BAND));
	end

	always_comb begin
		start      = (phase_q == tfd_pkg::PH_IDLE) && (opcode != tfd_pkg::OP_TICK);
		ph_eff     = phase_q;
		cnt_eff    = cnt_q;
		status_eff = status_q;
		if (start) begin
			cnt_eff = '0;
			unique case (opcode)
				tfd_pkg::OP_FILL: begin
					ph_eff = tfd_pkg::PH_FILL;
					status_eff = tfd_pkg::ST_FILL_RUN;
				end
				tfd_pkg::OP_REGULATE: begin
					ph_eff = tfd_pkg::PH_DOSE;
					status_eff = tfd_pkg::ST_REG_RUN;
				end
				default: begin
					ph_eff = tfd_pkg::PH_FLOOD;
					status_eff = tfd_pkg::ST_FLD_RUN;
				end
			endcase
		end
		cnt_inc = cnt_eff + 1'b1;

		phase_d  = ph_eff;
		cnt_d    = cnt_eff;
		status_d = status_eff;
		res      = '0;

		unique case (ph_eff)
			tfd_pkg::PH_IDLE: begin
			end
			tfd_pkg::PH_FILL: begin
				if (lvl_off) begin
					res.inlet_valve = 1'b1;
				end else begin
					status_d = tfd_pkg::ST_FILL_DONE;
					phase_d  = tfd_pkg::PH_IDLE;
				end
			end
			tfd_pkg::PH_DOSE: begin
				res.mixing_valve = 1'b1;
				res.flood_pump   = 1'b1;
				if (ph_off && cnt_eff < tfd_pkg::CNT_W'(tfd_pkg::DOSE_TICKS)) begin
					res.acid_pump = 1'b1;
					cnt_d = cnt_inc;
				end else begin
					// A pass without any acid means the pH was already in band.
					phase_d = (cnt_eff == '0) ? tfd_pkg::PH_HOLD : tfd_pkg::PH_SETTLE;
					cnt_d   = '0;
				end
			end
			tfd_pkg::PH_SETTLE: begin
				res.mixing_valve = 1'b1;
				res.flood_pump   = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc >= tfd_pkg::CNT_W'(tfd_pkg::SETTLE_TICKS)) begin
					phase_d = tfd_pkg::PH_DOSE;
					cnt_d   = '0;
				end
			end
			tfd_pkg::PH_HOLD: begin
				res.mixing_valve = 1'b1;
				res.flood_pump   = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc >= tfd_pkg::CNT_W'(tfd_pkg::HOLD_TICKS)) begin
					phase_d = tfd_pkg::PH_REST;
					cnt_d   = '0;
				end
			end
			tfd_pkg::PH_REST: begin
				res.mixing_valve = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc >= tfd_pkg::CNT_W'(tfd_pkg::HOLD_TICKS)) begin
					cnt_d = '0;
					if (ph_off) begin
						phase_d = tfd_pkg::PH_DOSE;
					end else begin
						status_d = tfd_pkg::ST_REG_DONE;
						phase_d  = tfd_pkg::PH_IDLE;
					end
				end
			end
			tfd_pkg::PH_FLOOD: begin
				if (cnt_eff < cfg.flood_total) begin
					res.outlet_valve = 1'b1;
					res.flood_pump   = 1'b1;
					cnt_d = cnt_inc;
				end else begin
					cnt_d    = '0;
					status_d = tfd_pkg::ST_FLD_DONE;
					phase_d  = tfd_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = tfd_pkg::PH_IDLE;
			end
		endcase
		res.status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tfd_pkg::PH_IDLE;
			cnt_q    <= '0;
			status_q <= tfd_pkg::ST_IDLE;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
		end
	end

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tfd_pkg::PH_IDLE |-> cnt_q == '0)
		else $error("tick counter not cleared while idle");

	a_dose_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tfd_pkg::PH_DOSE |-> cnt_q <= tfd_pkg::CNT_W'(tfd_pkg::DOSE_TICKS))
		else $error("dose counter ran past its limit");

	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tfd_pkg::PH_FLOOD |-> status_q == tfd_pkg::ST_FLD_RUN)
		else $error("flood running without flood run status");

endmodule

@@ rtl/tfd_skid.sv @@
// Output register with a skid stage that decouples the result channel.
// Depends on tfd_pkg.
module tfd_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tfd_pkg::res_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tfd_pkg::res_t out_data
);

	logic          out_valid_q, skid_valid_q;
	tfd_pkg::res_t out_data_q, skid_data_q;
	logic          take, pop;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid && !skid_valid_q;
	assign pop       = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (take) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (take) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q)
		else $error("skid entry lost when output was taken");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_valid_q && take && out_valid_q && out_stall |=> skid_valid_q)
		else $error("request dropped while output was stalled");

endmodule
